### design/assert_macros.svh
// Assertion macros used by the rasterizer design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### design/crm_pkg.sv
package crm_pkg;

  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;
  localparam int ROW_DEPTH     = 32;
  localparam int NUM_ROWS = (SCREEN_HEIGHT < ROW_DEPTH) ? SCREEN_HEIGHT : ROW_DEPTH;
  localparam int NUM_COLS = (SCREEN_WIDTH < 64) ? SCREEN_WIDTH : 64;
  localparam int MASK_W   = 64;
  localparam int ROW_AW   = $clog2(ROW_DEPTH);
  localparam int ROW_CW   = $clog2(NUM_ROWS + 1);
  localparam int COL_AW   = $clog2(MASK_W);

  // Wide enough for centre +/- radius on either axis.
  localparam int COORD_W  = 10;
  localparam int STEP_W   = 9;
  localparam int DEC_W    = 12;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [MASK_W-1:0]         mask_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DRAW,
    S_DRAIN,
    S_EMIT
  } state_t;

  localparam logic [1:0] SLOT_LOW_B  = 2'd0;
  localparam logic [1:0] SLOT_HIGH_B = 2'd1;
  localparam logic [1:0] SLOT_LOW_A  = 2'd2;
  localparam logic [1:0] SLOT_HIGH_A = 2'd3;

  // Columns xa..xb (xa <= xb), clipped to the screen.
  function automatic mask_t span_mask(input coord_t xa, input coord_t xb);
    coord_t            lo;
    coord_t            hi;
    logic [COL_AW-1:0] lo_c;
    logic [COL_AW-1:0] hi_c;
    mask_t             m;
    lo = (xa < 0) ? coord_t'(0) : xa;
    hi = (xb > coord_t'(NUM_COLS - 1)) ? coord_t'(NUM_COLS - 1) : xb;
    lo_c = lo[COL_AW-1:0];
    hi_c = hi[COL_AW-1:0];
    if (lo > hi) begin
      m = '0;
    end else begin
      m = ({MASK_W{1'b1}} >> (COL_AW'(MASK_W - 1) - hi_c)) & ({MASK_W{1'b1}} << lo_c);
    end
    return m;
  endfunction

  function automatic mask_t point_mask(input coord_t col);
    mask_t m;
    m = '0;
    if (col >= 0 && col < coord_t'(NUM_COLS)) begin
      m[col[COL_AW-1:0]] = 1'b1;
    end
    return m;
  endfunction

endpackage

### design/crm_if.sv
interface crm_circle_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] center_x;
  logic signed [7:0] center_y;
  logic [6:0]        circle_radius;
  logic              fill_enable;
  logic              border_enable;

  modport source (output valid, center_x, center_y, circle_radius, fill_enable, border_enable,
                  input ready);
  modport sink   (input valid, center_x, center_y, circle_radius, fill_enable, border_enable,
                  output ready);
endinterface

interface crm_row_if;
  logic        valid;
  logic        ready;
  logic [4:0]  row_index;
  logic [63:0] fill_mask;
  logic [63:0] border_mask;
  logic        last_row;

  modport source (output valid, row_index, fill_mask, border_mask, last_row, input ready);
  modport sink   (input valid, row_index, fill_mask, border_mask, last_row, output ready);
endinterface

### design/crm_ram.sv
module crm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### design/circle_row_mask_rasterizer.sv
// Channel  Dir  Beat
// -------  ---  ------------------------------------------------------------
// circle   in   one circle: center_x, center_y, circle_radius, enables
// row      out  one display row: row_index, fill_mask, border_mask, last_row
//
// A circle takes four slots per midpoint step (one row store read-modify-write per
// slot, about radius/1.41 + 1 steps), then a drain state, then a readout of all
// 32 rows. After reset a clearing pass runs through both row stores before the
// first circle is taken. Rows are cleared as they are read out. A stalled row
// beat holds the readout; the next circle is taken while the last row beat still
// waits.
`include "assert_macros.svh"

module circle_row_mask_rasterizer
  import crm_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  crm_circle_if.sink      circle,
  crm_row_if.source       row
);

  state_t state, state_next;

  // Circle and midpoint state
  coord_t                    cx, cy;
  logic                      fen, ben;
  logic signed [STEP_W-1:0]  a, b;
  logic signed [DEC_W-1:0]   d;
  logic [1:0]                slot;

  // Slot issue
  coord_t                    row_s, h, xa, xb;
  logic                      on_screen;
  mask_t                     slot_fill, slot_border;
  logic signed [STEP_W-1:0]  a_next, b_next;
  logic signed [DEC_W-1:0]   d_next;
  logic                      cont;

  // Write stage and forwarding
  logic                      p_valid;
  logic [ROW_AW-1:0]         p_row;
  mask_t                     p_fill, p_border;
  logic                      f_en;
  logic [ROW_AW-1:0]         f_addr;
  mask_t                     f_fill, f_border;

  // Memory ports
  logic                      wr_en;
  logic [ROW_AW-1:0]         wr_addr, rd_addr;
  mask_t                     wr_fill, wr_border, fill_rd, border_rd;
  logic                      fwd_hit;

  // Clear and readout
  logic [ROW_AW-1:0]         clr_idx;
  logic [ROW_CW-1:0]         e_idx;
  logic [ROW_AW-1:0]         e_row;
  logic                      pend;
  logic                      emit_issue;
  logic                      out_vld;
  logic [4:0]                out_row;
  mask_t                     out_fill, out_border;
  logic                      out_last;

  logic                      in_fire;

  assign in_fire = circle.valid && circle.ready;

  crm_ram #(.WIDTH(MASK_W), .DEPTH(ROW_DEPTH)) u_fill_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_fill),
    .rd_addr (rd_addr),
    .rd_data (fill_rd)
  );

  crm_ram #(.WIDTH(MASK_W), .DEPTH(ROW_DEPTH)) u_border_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_border),
    .rd_addr (rd_addr),
    .rd_data (border_rd)
  );

  // Slot geometry: rows cy+-b carry half-width a, rows cy+-a carry half-width b
  always_comb begin
    case (slot)
      SLOT_LOW_B: begin
        row_s = cy + coord_t'(b);
        h     = coord_t'(a);
      end
      SLOT_HIGH_B: begin
        row_s = cy - coord_t'(b);
        h     = coord_t'(a);
      end
      SLOT_LOW_A: begin
        row_s = cy + coord_t'(a);
        h     = coord_t'(b);
      end
      SLOT_HIGH_A: begin
        row_s = cy - coord_t'(a);
        h     = coord_t'(b);
      end
      default: begin
        row_s = cy;
        h     = '0;
      end
    endcase
    xa          = cx - h;
    xb          = cx + h;
    on_screen   = (row_s >= 0) && (row_s < coord_t'(NUM_ROWS));
    slot_fill   = fen ? span_mask(xa, xb) : '0;
    slot_border = ben ? (point_mask(xa) | point_mask(xb)) : '0;
  end

  // Midpoint step update
  always_comb begin
    a_next = a + STEP_W'(1);
    if (d < 0) begin
      d_next = d + (DEC_W'(a) <<< 2) + DEC_W'(6);
      b_next = b;
    end else begin
      d_next = d + (DEC_W'(a - b) <<< 2) + DEC_W'(10);
      b_next = b - STEP_W'(1);
    end
    cont = (b_next >= a_next);
  end

  assign emit_issue = (state == S_EMIT) && !pend && (!out_vld || row.ready) &&
                      (e_idx < ROW_CW'(NUM_ROWS));

  // Write port: clearing pass, draw merge, or clear-on-read during readout
  assign fwd_hit = f_en && (f_addr == p_row);

  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = e_row;
    wr_fill   = '0;
    wr_border = '0;
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx;
    end else if (p_valid) begin
      wr_en     = 1'b1;
      wr_addr   = p_row;
      wr_fill   = (fwd_hit ? f_fill : fill_rd) | p_fill;
      wr_border = (fwd_hit ? f_border : border_rd) | p_border;
    end else if (pend) begin
      wr_en   = 1'b1;
      wr_addr = e_row;
    end
  end

  assign rd_addr = (state == S_DRAW) ? row_s[ROW_AW-1:0] : e_idx[ROW_AW-1:0];

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_idx == ROW_AW'(NUM_ROWS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_next = S_DRAW;
        end
      end
      S_DRAW: begin
        if (slot == SLOT_HIGH_A && !cont) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (e_idx == ROW_CW'(NUM_ROWS) && !pend) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      slot    <= '0;
      p_valid <= 1'b0;
      f_en    <= 1'b0;
      pend    <= 1'b0;
      e_idx   <= '0;
      out_vld <= 1'b0;
    end else begin
      f_en <= wr_en;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + ROW_AW'(1);
      end
      if (in_fire) begin
        slot  <= '0;
        e_idx <= '0;
      end else if (state == S_DRAW) begin
        slot <= slot + 2'd1;
      end
      p_valid <= (state == S_DRAW) && on_screen;
      // Hold the row beat until taken; load a fresh one when its read returns
      if (pend) begin
        out_vld <= 1'b1;
      end else if (row.ready) begin
        out_vld <= 1'b0;
      end
      pend <= emit_issue;
      if (emit_issue) begin
        e_idx <= e_idx + ROW_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cx  <= coord_t'(circle.center_x);
      cy  <= coord_t'(circle.center_y);
      fen <= circle.fill_enable;
      ben <= circle.border_enable;
      a   <= '0;
      b   <= STEP_W'(circle.circle_radius);
      d   <= DEC_W'(3) - (DEC_W'(circle.circle_radius) <<< 1);
    end else if (state == S_DRAW && slot == SLOT_HIGH_A) begin
      a <= a_next;
      b <= b_next;
      d <= d_next;
    end
    p_row    <= row_s[ROW_AW-1:0];
    p_fill   <= slot_fill;
    p_border <= slot_border;
    f_addr   <= wr_addr;
    f_fill   <= wr_fill;
    f_border <= wr_border;
    if (emit_issue) begin
      e_row <= e_idx[ROW_AW-1:0];
    end
    if (pend) begin
      out_row    <= 5'(e_row);
      out_fill   <= fill_rd & ~border_rd;
      out_border <= border_rd;
      out_last   <= (e_row == ROW_AW'(NUM_ROWS - 1));
    end
  end

  assign circle.ready    = (state == S_IDLE);
  assign row.valid       = out_vld;
  assign row.row_index   = out_row;
  assign row.fill_mask   = out_fill;
  assign row.border_mask = out_border;
  assign row.last_row    = out_last;

  `ASSERT_IMPL(a_wr_one_src, clk, rst, 1'b1, $onehot0({state == S_CLEAR, p_valid, pend}), "write port driven by two sources")
  `ASSERT_IMPL(a_load_free, clk, rst, pend, !out_vld, "row readout overwrites a waiting beat")
  `ASSERT_IMPL(a_loop_bound, clk, rst, state == S_DRAW, b >= a, "midpoint loop ran past its end")
  `ASSERT_NEXT(a_start_step, clk, rst, in_fire, state == S_DRAW && a == 0 && slot == SLOT_LOW_B, "circle did not start at the first step")

endmodule

### sim/circle_row_mask_rasterizer_tb.sv
`timescale 1ns / 1ps

module circle_row_mask_rasterizer_tb
  import crm_pkg::*;
();

  localparam int RANDOM_ITEMS = 187;

  typedef struct packed {
    logic signed [7:0] cx;
    logic signed [7:0] cy;
    logic [6:0]        radius;
    logic              fill_en;
    logic              border_en;
  } circle_t;

  typedef struct packed {
    logic [4:0]  row_index;
    logic [63:0] fill_mask;
    logic [63:0] border_mask;
    logic        last_row;
  } row_beat_t;

  // typed: expect all rows blank except hit_row (none when negative)
  typedef struct packed {
    circle_t           circ;
    logic              typed;
    logic signed [5:0] hit_row;
    logic [63:0]       hit_fill;
    logic [63:0]       hit_border;
  } plan_row_t;

  localparam int PLAN_LEN = 23;
  localparam plan_row_t DIRECTED_PLAN [PLAN_LEN] = '{
    '{'{8'sd0, 8'sd0, 7'd0, 1'b0, 1'b0}, 1'b1, -6'sd1, 64'h0, 64'h0},
    '{'{8'sd0, 8'sd0, 7'd0, 1'b1, 1'b0}, 1'b1, 6'sd0, 64'h1, 64'h0},
    '{'{8'sd0, 8'sd0, 7'd0, 1'b1, 1'b1}, 1'b1, 6'sd0, 64'h0, 64'h1},
    '{'{8'sd63, 8'sd31, 7'd0, 1'b0, 1'b1}, 1'b1, 6'sd31, 64'h0, 64'h8000_0000_0000_0000},
    '{'{8'sh80, 8'sh80, 7'd127, 1'b1, 1'b1}, 1'b1, -6'sd1, 64'h0, 64'h0},
    '{'{8'sh80, 8'sd127, 7'd127, 1'b1, 1'b1}, 1'b1, -6'sd1, 64'h0, 64'h0},
    '{'{8'sd127, 8'sh80, 7'd127, 1'b1, 1'b1}, 1'b1, -6'sd1, 64'h0, 64'h0},
    '{'{8'sd127, 8'sd127, 7'd127, 1'b1, 1'b1}, 1'b0, -6'sd1, 64'h0, 64'h0},
    '{'{8'sd32, 8'sd16, 7'd127, 1'b1, 1'b0}, 1'b0, -6'sd1, 64'h0, 64'h0},
    '{'{8'sd32, 8'sd16, 7'd10, 1'b0, 1'b1}, 1'b0, -6'sd1, 64'h0, 64'h0},
    '{'{8'sd32, 8'sd16, 7'd10, 1'b1, 1'b0}, 1'b0, -6'sd1, 64'h0, 64'h0},
    '{'{8'sd32, 8'sd16, 7'd10, 1'b1, 1'b1}, 1'b0, -6'sd1, 64'h0, 64'h0},
    '{'{8'sd5, 8'sd5, 7'd12, 1'b1, 1'b1}, 1'b0, -6'sd1, 64'h0, 64'h0},
    '{'{8'sd60, 8'sd28, 7'd9, 1'b1, 1'b1}, 1'b0, -6'sd1, 64'h0, 64'h0},
    '{'{-8'sd3, 8'sd15, 7'd6, 1'b1, 1'b1}, 1'b0, -6'sd1, 64'h0, 64'h0},
    '{'{8'sd70, 8'sd10, 7'd8, 1'b1, 1'b1}, 1'b0, -6'sd1, 64'h0, 64'h0},
    '{'{8'sd20, -8'sd5, 7'd7, 1'b1, 1'b1}, 1'b0, -6'sd1, 64'h0, 64'h0},
    '{'{8'sd20, 8'sd36, 7'd7, 1'b1, 1'b1}, 1'b0, -6'sd1, 64'h0, 64'h0},
    '{'{8'sd31, 8'sd15, 7'd1, 1'b1, 1'b1}, 1'b0, -6'sd1, 64'h0, 64'h0},
    '{'{8'sd31, 8'sd15, 7'd2, 1'b0, 1'b1}, 1'b0, -6'sd1, 64'h0, 64'h0},
    '{'{8'sd10, 8'sd20, 7'd63, 1'b1, 1'b1}, 1'b0, -6'sd1, 64'h0, 64'h0},
    '{'{-8'sd1, -8'sd1, 7'd1, 1'b1, 1'b0}, 1'b0, -6'sd1, 64'h0, 64'h0},
    '{'{8'sd0, 8'sd0, 7'd64, 1'b1, 1'b1}, 1'b0, -6'sd1, 64'h0, 64'h0}
  };

  logic clk = 1'b0;
  logic rst;

  crm_circle_if circ_bus();
  crm_row_if    row_bus();

  circle_row_mask_rasterizer uut (
    .clk    (clk),
    .rst    (rst),
    .circle (circ_bus),
    .row    (row_bus)
  );

  row_beat_t   expected_rows[$];
  logic [63:0] pred_fill   [NUM_ROWS];
  logic [63:0] pred_border [NUM_ROWS];
  int          mismatch_count = 0;
  bit          hold_rows;
  bit          no_idle;

  always #5 clk = ~clk;

  function automatic void or_span(input int xa, input int xb, input int y);
    int lo;
    int hi;
    int i;
    if (y < 0 || y >= NUM_ROWS) return;
    lo = (xa < xb) ? xa : xb;
    hi = (xa < xb) ? xb : xa;
    if (lo < 0) lo = 0;
    if (hi > NUM_COLS - 1) hi = NUM_COLS - 1;
    for (i = lo; i <= hi; i++) pred_fill[y][i] = 1'b1;
  endfunction

  function automatic void or_dot(input int x, input int y);
    if (x < 0 || x >= NUM_COLS || y < 0 || y >= NUM_ROWS) return;
    pred_border[y][x] = 1'b1;
  endfunction

  // Midpoint circle, fill layer then border layer, then queue one beat per row.
  task automatic predict_rows(input circle_t c);
    int cx;
    int cy;
    int a;
    int b;
    int d;
    int layer;
    int y;
    cx = $signed(c.cx);
    cy = $signed(c.cy);
    for (y = 0; y < NUM_ROWS; y++) begin
      pred_fill[y]   = '0;
      pred_border[y] = '0;
    end
    for (layer = 0; layer < 2; layer++) begin
      if ((layer == 0) ? c.fill_en : c.border_en) begin
        a = 0;
        b = c.radius;
        d = 3 - 2 * b;
        while (b >= a) begin
          if (layer == 0) begin
            or_span(cx - a, cx + a, cy + b);
            or_span(cx - a, cx + a, cy - b);
            or_span(cx - b, cx + b, cy + a);
            or_span(cx - b, cx + b, cy - a);
          end else begin
            or_dot(cx + a, cy + b);
            or_dot(cx - a, cy + b);
            or_dot(cx + a, cy - b);
            or_dot(cx - a, cy - b);
            or_dot(cx + b, cy + a);
            or_dot(cx - b, cy + a);
            or_dot(cx + b, cy - a);
            or_dot(cx - b, cy - a);
          end
          if (d < 0) begin
            d = d + 4 * a + 6;
          end else begin
            d = d + 4 * (a - b) + 10;
            b--;
          end
          a++;
        end
      end
    end
    for (y = 0; y < NUM_ROWS; y++) begin
      expected_rows.push_back({5'(y), pred_fill[y] & ~pred_border[y], pred_border[y],
                               y == NUM_ROWS - 1});
    end
  endtask

  function automatic circle_t pick_circle();
    circle_t c;
    int      en;
    if ($urandom_range(0, 4) == 0) begin
      c.cx        = 8'($urandom_range(0, 255));
      c.cy        = 8'($urandom_range(0, 255));
      c.radius    = 7'($urandom_range(0, 127));
      c.fill_en   = 1'($urandom_range(0, 1));
      c.border_en = 1'($urandom_range(0, 1));
    end else begin
      // keep most circles near the screen and small enough to stay quick
      c.cx     = 8'(int'($urandom_range(0, 84)) - 10);
      c.cy     = 8'(int'($urandom_range(0, 52)) - 10);
      c.radius = 7'($urandom_range(0, ($urandom_range(0, 5) == 0) ? 60 : 20));
      en = $urandom_range(0, 5);
      c.fill_en   = (en != 5);
      c.border_en = (en != 4);
    end
    return c;
  endfunction

  task automatic offer_circle(input circle_t c, input int gap, input bit settle);
    if (gap > 0 || settle) circ_bus.valid <= 1'b0;
    if (settle) begin
      wait (expected_rows.size() == 0);
      @(posedge clk);
    end
    repeat (gap) @(posedge clk);
    circ_bus.valid         <= 1'b1;
    circ_bus.center_x      <= c.cx;
    circ_bus.center_y      <= c.cy;
    circ_bus.circle_radius <= c.radius;
    circ_bus.fill_enable   <= c.fill_en;
    circ_bus.border_enable <= c.border_en;
    do @(posedge clk); while (!circ_bus.ready);
  endtask

  initial begin
    int        k;
    int        y;
    circle_t   c;
    plan_row_t p;
    rst                    = 1'b1;
    circ_bus.valid         = 1'b0;
    circ_bus.center_x      = '0;
    circ_bus.center_y      = '0;
    circ_bus.circle_radius = '0;
    circ_bus.fill_enable   = 1'b0;
    circ_bus.border_enable = 1'b0;
    hold_rows              = 1'b0;
    no_idle                = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < PLAN_LEN; k++) begin
      p = DIRECTED_PLAN[k];
      offer_circle(p.circ, $urandom_range(0, 12), 1'b0);
      if (p.typed) begin
        for (y = 0; y < NUM_ROWS; y++) begin
          expected_rows.push_back({5'(y), (y == p.hit_row) ? p.hit_fill : 64'h0,
                                   (y == p.hit_row) ? p.hit_border : 64'h0,
                                   y == NUM_ROWS - 1});
        end
      end else begin
        predict_rows(p.circ);
      end
    end

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      // stall the row side for a long stretch so the circle input backs up
      if (k == 60) hold_rows = 1'b1;
      no_idle = (k >= 140 && k < 176);
      c = pick_circle();
      offer_circle(c, no_idle ? 0 : $urandom_range(0, 12), k == 120);
      predict_rows(c);
    end
    circ_bus.valid <= 1'b0;
    no_idle = 1'b0;

    wait (expected_rows.size() == 0);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && expected_rows.size() == 0) begin
      $display("circle_row_mask_rasterizer_tb: PASS");
    end else begin
      $display("circle_row_mask_rasterizer_tb: FAIL");
    end
    $finish;
  end

  initial begin
    int stall;
    bit held;
    held          = 1'b0;
    row_bus.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 12);
      if (hold_rows && !held) begin
        stall = 400;
        held  = 1'b1;
      end
      if (stall > 0) begin
        row_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      row_bus.ready <= 1'b1;
      do @(posedge clk); while (!row_bus.valid);
    end
  end

  always @(posedge clk) begin
    row_beat_t got;
    row_beat_t want;
    if (!rst && row_bus.valid && row_bus.ready) begin
      got = {row_bus.row_index, row_bus.fill_mask, row_bus.border_mask, row_bus.last_row};
      if (expected_rows.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected row beat: row %0d fill %h border %h last %b",
                   got.row_index, got.fill_mask, got.border_mask, got.last_row);
      end else begin
        want = expected_rows.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("row mismatch: expected row %0d fill %h border %h last %b",
                     want.row_index, want.fill_mask, want.border_mask, want.last_row);
            $display("              got      row %0d fill %h border %h last %b",
                     got.row_index, got.fill_mask, got.border_mask, got.last_row);
          end
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("circle_row_mask_rasterizer_tb: FAIL");
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/crm_pkg.sv
design/crm_if.sv
design/crm_ram.sv
design/circle_row_mask_rasterizer.sv
sim/circle_row_mask_rasterizer_tb.sv
